@@ hdl/vjal_pkg.sv @@
`default_nettype none
package vjal_pkg;

    // Divider geometry: numerator 2*|lim|*2^16 + |req| fits 49 bits
    localparam int DIV_BITS = 49;
    localparam int DEN_W    = 33;
    localparam int REM_W    = DEN_W + 1;

    // Register indexes
    localparam logic [2:0] REG_ENABLES    = 3'd0;
    localparam logic [2:0] REG_VEL_FLOOR  = 3'd1;
    localparam logic [2:0] REG_VEL_CEIL   = 3'd2;
    localparam logic [2:0] REG_ACC_FLOOR  = 3'd3;
    localparam logic [2:0] REG_ACC_CEIL   = 3'd4;
    localparam logic [2:0] REG_JERK_FLOOR = 3'd5;
    localparam logic [2:0] REG_JERK_CEIL  = 3'd6;

    // Enable bits
    localparam int EN_VEL  = 0;
    localparam int EN_ACC  = 1;
    localparam int EN_JERK = 2;

    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    typedef struct packed {
        logic signed [31:0] req;
        logic signed [31:0] v0;
        logic signed [31:0] v1;
        logic        [31:0] dt;
    } t_item;

    typedef struct packed {
        logic signed [31:0] acc_lo;
        logic signed [31:0] acc_hi;
        logic signed [31:0] jerk_lo;
        logic signed [31:0] jerk_hi;
    } t_bounds;

    // Saturate a signed 64-bit value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647)       r = 32'sh7fffffff;
        else if (x < -64'sd2147483648) r = 32'sh80000000;
        else                           r = x[31:0];
        return r;
    endfunction

    // Q15.16 times Q8.24, rounded back to Q15.16, saturated
    function automatic logic signed [31:0] mul_dt(input logic signed [31:0] a,
                                                  input logic [31:0] dt);
        logic signed [64:0] p;
        logic signed [64:0] s;
        p = a * $signed({1'b0, dt});
        s = p + 65'sd8388608;
        return sat32({{23{s[64]}}, s[64:24]});
    endfunction

    // Second rounding step of the jerk bound, doubled
    function automatic logic signed [31:0] jerk_dt(input logic signed [31:0] t,
                                                   input logic [31:0] dt);
        logic signed [64:0] p;
        logic signed [64:0] s;
        p = t * $signed({1'b0, dt});
        s = p + 65'sd8388608;
        return sat32({{22{s[64]}}, s[64:24], 1'b0});
    endfunction

endpackage
`default_nettype wire

@@ hdl/vjal_bound.sv @@
`default_nettype none
module vjal_bound import vjal_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_item              i_item,
    input  wire logic signed [31:0] i_acc_floor,
    input  wire logic signed [31:0] i_acc_ceil,
    input  wire logic signed [31:0] i_jerk_floor,
    input  wire logic signed [31:0] i_jerk_ceil,
    output logic                    o_valid,
    output t_item                   o_item,
    output t_bounds                 o_bounds
);

    logic               r_vld1, r_vld2;
    t_item              r_item1, r_item2;
    t_bounds            r_b1, r_b2;
    t_bounds            n_b1, n_b2;

    // stage 1: limit times dt
    always_comb begin
        n_b1.acc_lo  = mul_dt(i_acc_floor, i_item.dt);
        n_b1.acc_hi  = mul_dt(i_acc_ceil, i_item.dt);
        n_b1.jerk_lo = mul_dt(i_jerk_floor, i_item.dt);
        n_b1.jerk_hi = mul_dt(i_jerk_ceil, i_item.dt);
    end

    // stage 2: jerk bounds times dt again, doubled
    always_comb begin
        n_b2         = r_b1;
        n_b2.jerk_lo = jerk_dt(r_b1.jerk_lo, r_item1.dt);
        n_b2.jerk_hi = jerk_dt(r_b1.jerk_hi, r_item1.dt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
        r_item1 <= i_item;
        r_b1    <= n_b1;
        r_item2 <= r_item1;
        r_b2    <= n_b2;
    end

    assign o_valid  = r_vld2;
    assign o_item   = r_item2;
    assign o_bounds = r_b2;

endmodule
`default_nettype wire

@@ hdl/vjal_clamp.sv @@
`default_nettype none
module vjal_clamp import vjal_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_item              i_item,
    input  wire t_bounds            i_bounds,
    input  wire logic [2:0]         i_enables,
    input  wire logic signed [31:0] i_vel_floor,
    input  wire logic signed [31:0] i_vel_ceil,
    output logic                    o_valid,
    output logic signed [31:0]      o_limited,
    output logic signed [31:0]      o_req
);

    logic               r_vld3, r_vld4, r_vld5;
    logic signed [31:0] r_v3, r_v4, r_v5;
    logic signed [31:0] r_v0_3;
    logic signed [31:0] r_req3, r_req4, r_req5;
    logic signed [31:0] r_alo3, r_ahi3;
    logic signed [31:0] n_v3, n_v4, n_v5;

    // jerk stage: clamp req - 2*v0 + v1, rebuild 2*v0 - v1 + dd
    always_comb begin
        logic signed [35:0] dd;
        logic signed [35:0] lo;
        logic signed [35:0] hi;
        logic signed [35:0] vn;
        dd = {{4{i_item.req[31]}}, i_item.req} - {{3{i_item.v0[31]}}, i_item.v0, 1'b0}
             + {{4{i_item.v1[31]}}, i_item.v1};
        lo = {{4{i_bounds.jerk_lo[31]}}, i_bounds.jerk_lo};
        hi = {{4{i_bounds.jerk_hi[31]}}, i_bounds.jerk_hi};
        if (dd < lo) dd = lo;
        if (dd > hi) dd = hi;
        vn = {{3{i_item.v0[31]}}, i_item.v0, 1'b0} - {{4{i_item.v1[31]}}, i_item.v1} + dd;
        n_v3 = i_enables[EN_JERK] ? sat32({{28{vn[35]}}, vn}) : i_item.req;
    end

    // acceleration stage: clamp v - v0
    always_comb begin
        logic signed [33:0] d;
        logic signed [33:0] lo;
        logic signed [33:0] hi;
        logic signed [33:0] vn;
        d  = {{2{r_v3[31]}}, r_v3} - {{2{r_v0_3[31]}}, r_v0_3};
        lo = {{2{r_alo3[31]}}, r_alo3};
        hi = {{2{r_ahi3[31]}}, r_ahi3};
        if (d < lo) d = lo;
        if (d > hi) d = hi;
        vn = {{2{r_v0_3[31]}}, r_v0_3} + d;
        n_v4 = i_enables[EN_ACC] ? sat32({{30{vn[33]}}, vn}) : r_v3;
    end

    // velocity stage: floor first, then ceiling
    always_comb begin
        n_v5 = r_v4;
        if (i_enables[EN_VEL]) begin
            if (n_v5 < i_vel_floor) n_v5 = i_vel_floor;
            if (n_v5 > i_vel_ceil)  n_v5 = i_vel_ceil;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            r_vld3 <= i_valid;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
        end
        r_v3   <= n_v3;
        r_v0_3 <= i_item.v0;
        r_req3 <= i_item.req;
        r_alo3 <= i_bounds.acc_lo;
        r_ahi3 <= i_bounds.acc_hi;
        r_v4   <= n_v4;
        r_req4 <= r_req3;
        r_v5   <= n_v5;
        r_req5 <= r_req4;
    end

    assign o_valid   = r_vld5;
    assign o_limited = r_v5;
    assign o_req     = r_req5;

endmodule
`default_nettype wire

@@ hdl/vjal_div.sv @@
`default_nettype none
module vjal_div import vjal_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic signed [31:0] i_limited,
    input  wire logic signed [31:0] i_req,
    output logic                    o_valid,
    output logic signed [31:0]      o_limited,
    output logic signed [31:0]      o_ratio
);

    // index 0 is the setup register, then one quotient bit per stage
    logic                  r_vld  [DIV_BITS+1];
    logic [DIV_BITS-1:0]   r_num  [DIV_BITS+1];
    logic [DIV_BITS-1:0]   r_quo  [DIV_BITS+1];
    logic [DEN_W-1:0]      r_rem  [DIV_BITS+1];
    logic [DEN_W-1:0]      r_den  [DIV_BITS+1];
    logic                  r_neg  [DIV_BITS+1];
    logic                  r_zreq [DIV_BITS+1];
    logic                  r_zlim [DIV_BITS+1];
    logic signed [31:0]    r_lim  [DIV_BITS+1];
    logic [DIV_BITS-1:0]   n_num  [DIV_BITS+1];
    logic [DIV_BITS-1:0]   n_quo  [DIV_BITS+1];
    logic [DEN_W-1:0]      n_rem  [DIV_BITS+1];

    logic                  r_out_vld;
    logic signed [31:0]    r_out_lim;
    logic signed [31:0]    r_out_ratio;
    logic signed [31:0]    n_ratio;

    logic [31:0]           abs_lim;
    logic [31:0]           abs_req;
    logic [DIV_BITS-1:0]   setup_num;

    // setup: magnitudes, numerator 2*|lim|*2^16 + |req|, denominator 2*|req|
    assign abs_lim   = i_limited[31] ? 32'(-i_limited) : i_limited;
    assign abs_req   = i_req[31] ? 32'(-i_req) : i_req;
    assign setup_num = {abs_lim, 17'd0} + {17'd0, abs_req};

    // restoring division, one bit per stage
    always_comb begin
        logic [REM_W-1:0] t;
        n_num[0] = '0;
        n_quo[0] = '0;
        n_rem[0] = '0;
        for (int k = 1; k <= DIV_BITS; k++) begin
            t = {r_rem[k-1], r_num[k-1][DIV_BITS-1]};
            n_num[k] = {r_num[k-1][DIV_BITS-2:0], 1'b0};
            if (t >= {1'b0, r_den[k-1]}) begin
                n_rem[k] = DEN_W'(t - {1'b0, r_den[k-1]});
                n_quo[k] = {r_quo[k-1][DIV_BITS-2:0], 1'b1};
            end else begin
                n_rem[k] = t[DEN_W-1:0];
                n_quo[k] = {r_quo[k-1][DIV_BITS-2:0], 1'b0};
            end
        end
    end

    // sign, saturation and special cases
    always_comb begin
        logic [DIV_BITS-1:0] q;
        q = r_quo[DIV_BITS];
        if (r_zreq[DIV_BITS])
            n_ratio = ONE_Q16;
        else if (r_zlim[DIV_BITS])
            n_ratio = '0;
        else if (r_neg[DIV_BITS])
            n_ratio = (q > DIV_BITS'(64'd2147483648)) ? 32'sh80000000 : 32'(-q);
        else
            n_ratio = (q > DIV_BITS'(64'd2147483647)) ? 32'sh7fffffff : q[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_BITS; k++) r_vld[k] <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= DIV_BITS; k++) r_vld[k] <= r_vld[k-1];
            r_out_vld <= r_vld[DIV_BITS];
        end
        r_num[0]  <= setup_num;
        r_quo[0]  <= '0;
        r_rem[0]  <= '0;
        r_den[0]  <= {abs_req, 1'b0};
        r_neg[0]  <= i_limited[31] ^ i_req[31];
        r_zreq[0] <= (i_req == 32'sd0);
        r_zlim[0] <= (i_limited == 32'sd0);
        r_lim[0]  <= i_limited;
        for (int k = 1; k <= DIV_BITS; k++) begin
            r_num[k]  <= n_num[k];
            r_quo[k]  <= n_quo[k];
            r_rem[k]  <= n_rem[k];
            r_den[k]  <= r_den[k-1];
            r_neg[k]  <= r_neg[k-1];
            r_zreq[k] <= r_zreq[k-1];
            r_zlim[k] <= r_zlim[k-1];
            r_lim[k]  <= r_lim[k-1];
        end
        r_out_lim   <= r_lim[DIV_BITS];
        r_out_ratio <= n_ratio;
    end

    assign o_valid   = r_out_vld;
    assign o_limited = r_out_lim;
    assign o_ratio   = r_out_ratio;

endmodule
`default_nettype wire

@@ hdl/velocity_jerk_accel_limiter.sv @@
// Jerk, acceleration and velocity limiter with limited/requested ratio.
// Pipeline from start to done: 2 multiply stages, 3 clamp stages,
// a 49-stage one-bit-per-stage divider plus setup and output registers.
// Throughput: one word per cycle; busy stays low and results cannot be stalled.
// Reset (synchronous, active low) clears the pipeline valid bits and all
// configuration registers to zero.
`default_nettype none
module velocity_jerk_accel_limiter import vjal_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic signed [31:0] i_requested_velocity,
    input  wire logic signed [31:0] i_last_velocity,
    input  wire logic signed [31:0] i_older_velocity,
    input  wire logic        [31:0] i_time_step,
    output logic                    o_done,
    output logic signed [31:0]      o_limited_velocity,
    output logic signed [31:0]      o_scale_ratio,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    logic [2:0]         r_enables;
    logic signed [31:0] r_vel_floor, r_vel_ceil;
    logic signed [31:0] r_acc_floor, r_acc_ceil;
    logic signed [31:0] r_jerk_floor, r_jerk_ceil;

    t_item              in_item;
    logic               in_valid;
    logic               b_valid;
    t_item              b_item;
    t_bounds            b_bounds;
    logic               c_valid;
    logic signed [31:0] c_limited;
    logic signed [31:0] c_req;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign in_valid    = i_start & ~o_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enables    <= '0;
            r_vel_floor  <= '0;
            r_vel_ceil   <= '0;
            r_acc_floor  <= '0;
            r_acc_ceil   <= '0;
            r_jerk_floor <= '0;
            r_jerk_ceil  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ENABLES:    r_enables    <= i_cfg_data[2:0];
                REG_VEL_FLOOR:  r_vel_floor  <= i_cfg_data;
                REG_VEL_CEIL:   r_vel_ceil   <= i_cfg_data;
                REG_ACC_FLOOR:  r_acc_floor  <= i_cfg_data;
                REG_ACC_CEIL:   r_acc_ceil   <= i_cfg_data;
                REG_JERK_FLOOR: r_jerk_floor <= i_cfg_data;
                REG_JERK_CEIL:  r_jerk_ceil  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_item.req = i_requested_velocity;
    assign in_item.v0  = i_last_velocity;
    assign in_item.v1  = i_older_velocity;
    assign in_item.dt  = i_time_step;

    vjal_bound u_bound (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_valid),
        .i_item       (in_item),
        .i_acc_floor  (r_acc_floor),
        .i_acc_ceil   (r_acc_ceil),
        .i_jerk_floor (r_jerk_floor),
        .i_jerk_ceil  (r_jerk_ceil),
        .o_valid      (b_valid),
        .o_item       (b_item),
        .o_bounds     (b_bounds)
    );

    vjal_clamp u_clamp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (b_valid),
        .i_item      (b_item),
        .i_bounds    (b_bounds),
        .i_enables   (r_enables),
        .i_vel_floor (r_vel_floor),
        .i_vel_ceil  (r_vel_ceil),
        .o_valid     (c_valid),
        .o_limited   (c_limited),
        .o_req       (c_req)
    );

    vjal_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (c_valid),
        .i_limited (c_limited),
        .i_req     (c_req),
        .o_valid   (o_done),
        .o_limited (o_limited_velocity),
        .o_ratio   (o_scale_ratio)
    );

endmodule
`default_nettype wire
